// File: rtl/assert_macros.svh
// Assertion macros used by the deframer frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define RPD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define RPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RPD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define RPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/rpd_pkg.sv
// Types and constants shared by the response packet deframer.
`timescale 1ns / 1ps
package rpd_pkg;

  localparam int unsigned BYTE_W = 8;

  // Header is type, size and subtype; the first body byte has index 3.
  localparam logic [BYTE_W-1:0] HEADER_LEN = 8'd3;
  // Frames shorter than this cannot hold a body and a checksum.
  localparam logic [BYTE_W-1:0] MIN_FRAME  = 8'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SUBTYPE = 1'b1;

  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_SIZE    = 2'd1,
    PH_SUBTYPE = 2'd2,
    PH_BODY    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_PENDING   = 2'd0,
    ST_OK        = 2'd1,
    ST_TOO_SHORT = 2'd2,
    ST_BAD_SUM   = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] frame_size;
    logic              is_last;
    status_t           frame_status;
  } result_t;

endpackage

// File: rtl/rpd_in_if.sv
// Input byte channel of the deframer.
`timescale 1ns / 1ps
interface rpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/rpd_out_if.sv
// Output body byte channel of the deframer.
`timescale 1ns / 1ps
interface rpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic [7:0] byte_index;
  logic [7:0] frame_size;
  logic       is_last;
  logic [1:0] frame_status;

  modport source (output valid, output body_byte, output byte_index, output frame_size,
                  output is_last, output frame_status, input ready);
  modport sink   (input valid, input body_byte, input byte_index, input frame_size,
                  input is_last, input frame_status, output ready);
endinterface

// File: rtl/rpd_frame_fsm.sv
// Frame parser: configuration registers, phase tracking, checksum and result build.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rpd_frame_fsm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           step,
  input  logic [7:0]                     rx_byte,
  output logic                           res_valid,
  output rpd_pkg::result_t               res
);
  import rpd_pkg::*;

  logic [BYTE_W-1:0] response_type_code;
  logic [BYTE_W-1:0] table_subtype_code;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] size_held, size_held_next;
  logic [BYTE_W-1:0] next_index, next_index_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;

  logic [BYTE_W-1:0] sum_plus;
  logic              last;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_type_code <= '0;
      table_subtype_code <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESPONSE_TYPE: response_type_code <= cfg_data;
        CFG_TABLE_SUBTYPE: table_subtype_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sum_plus = running_sum + rx_byte;
  assign last     = ({1'b0, next_index} + 9'd1) >= {1'b0, size_held};

  always_comb begin
    phase_next       = phase;
    size_held_next   = size_held;
    next_index_next  = next_index;
    running_sum_next = running_sum;
    res_valid        = 1'b0;
    res.body_byte    = rx_byte;
    res.byte_index   = next_index;
    res.frame_size   = size_held;
    res.is_last      = last;
    res.frame_status = ST_PENDING;
    unique case (phase)
      PH_TYPE: begin
        if (rx_byte == response_type_code) begin
          running_sum_next = rx_byte;
          phase_next       = PH_SIZE;
        end
      end
      PH_SIZE: begin
        size_held_next   = rx_byte;
        running_sum_next = sum_plus;
        phase_next       = PH_SUBTYPE;
      end
      PH_SUBTYPE: begin
        if (rx_byte == table_subtype_code) begin
          running_sum_next = sum_plus;
          next_index_next  = HEADER_LEN;
          phase_next       = PH_BODY;
        end else begin
          phase_next = PH_TYPE;
        end
      end
      PH_BODY: begin
        res_valid        = 1'b1;
        running_sum_next = sum_plus;
        if (last) begin
          if (size_held < MIN_FRAME) begin
            res.frame_status = ST_TOO_SHORT;
          end else if (sum_plus == '0) begin
            res.frame_status = ST_OK;
          end else begin
            res.frame_status = ST_BAD_SUM;
          end
          phase_next      = PH_TYPE;
          next_index_next = '0;
        end else begin
          next_index_next = next_index + 8'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      size_held   <= '0;
      next_index  <= '0;
      running_sum <= '0;
    end else if (step) begin
      phase       <= phase_next;
      size_held   <= size_held_next;
      next_index  <= next_index_next;
      running_sum <= running_sum_next;
    end
  end

  `RPD_ASSERT_IMPLIES(a_body_index, clk, rst, phase == PH_BODY, next_index >= HEADER_LEN, "body index below header length")
  `RPD_ASSERT_IMPLIES(a_pending_not_last, clk, rst, res_valid && !res.is_last, res.frame_status == ST_PENDING, "non-final byte carries a final status")
  `RPD_ASSERT_NEXT(a_last_closes, clk, rst, step && res_valid && res.is_last, phase == PH_TYPE && next_index == '0, "frame not closed after final byte")
  `RPD_ASSERT_NEXT(a_bad_subtype, clk, rst, step && phase == PH_SUBTYPE && rx_byte != table_subtype_code, phase == PH_TYPE, "wrong subtype did not abandon frame")

endmodule

// File: rtl/rpd_out_stage.sv
// Output register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps
module rpd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             res_valid,
  input  rpd_pkg::result_t res,
  output logic             can_accept,
  rpd_out_if.source        tx
);
  import rpd_pkg::*;

  logic    valid;
  result_t data;

  // The register frees up in the same cycle its content is taken.
  assign can_accept = !valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (step) begin
      valid <= res_valid;
    end else if (tx.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      data <= res;
    end
  end

  assign tx.valid        = valid;
  assign tx.body_byte    = data.body_byte;
  assign tx.byte_index   = data.byte_index;
  assign tx.frame_size   = data.frame_size;
  assign tx.is_last      = data.is_last;
  assign tx.frame_status = data.frame_status;

endmodule

// File: rtl/response_packet_deframer_core.sv
// Top level of the response packet deframer: byte in, framed body bytes out.
// A body byte transferred in at one clock edge is shown on tx right after that edge.
// Throughput: one byte per cycle while tx keeps taking results; the single output register sets
// the limit and frees up in the same cycle its result is transferred out.
// Header and dropped bytes produce no result but still need a free output register to be taken.
// Reset (rst, synchronous, active high) clears both codes, the phase and the frame counters.
`timescale 1ns / 1ps
module response_packet_deframer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  rpd_in_if.sink                        rx,
  rpd_out_if.source                     tx
);
  import rpd_pkg::*;

  // A transfer on rx advances the parser exactly once.
  logic    step;
  logic    can_accept;
  logic    res_valid;
  result_t res;

  // A new byte is taken whenever the output register is empty or is being emptied,
  // so the parser never stalls while the downstream side keeps pace.
  assign rx.ready = can_accept;
  assign step     = rx.valid && can_accept;

  // The parser works directly on the incoming byte against its stored frame state;
  // the result of a body byte lands in the output register at the same edge.
  rpd_frame_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .rx_byte   (rx.rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  rpd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .res_valid  (res_valid),
    .res        (res),
    .can_accept (can_accept),
    .tx         (tx)
  );

endmodule

// File: dv/response_packet_deframer_core_test.sv
// Self-checking testbench for the response packet deframer core.
`timescale 1ns / 1ps
module response_packet_deframer_core_test;
  import rpd_pkg::*;

  // A result is registered at the edge that takes its byte; the settle cycles cover any header
  // byte that is still in flight when the last expected body byte has come out.
  localparam int SETTLE_CYCLES  = 4;
  // The longest correct quiet spell is a receiver stall or a drain with a code write,
  // both far below this count of cycles without any transfer.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  rpd_in_if  rx_ch ();
  rpd_out_if tx_ch ();

  response_packet_deframer_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rx       (rx_ch),
    .tx       (tx_ch)
  );

  // 20 ns clock period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Bytes waiting to be offered on the input channel, and body bytes that the
  // deframer still owes on its output channel, oldest first.
  logic [7:0] pending_bytes[$];
  result_t    expected_bodies[$];

  // Idle rates in percent for the sender and the receiver.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Codes that the stimulus uses to build headers.
  logic [7:0] hdr_type    = 8'h00;
  logic [7:0] hdr_subtype = 8'h00;

  // Our own copy of the deframer: its code registers and its framing state.
  logic [7:0] type_code    = 8'h00;
  logic [7:0] subtype_code = 8'h00;
  phase_t     rx_phase     = PH_TYPE;
  logic [7:0] held_size    = 8'h00;
  logic [7:0] body_index   = 8'h00;
  logic [7:0] frame_sum    = 8'h00;

  int error_count    = 0;
  int idle_cycles    = 0;
  int bytes_sent     = 0;
  int bodies_checked = 0;
  int frames_ok      = 0;
  int frames_short   = 0;
  int frames_bad_sum = 0;

  // Advances our copy of the deframer by one received byte. Header bytes and
  // dropped bytes only move the state; each body byte adds one expected result.
  task predict_deframe(input logic [7:0] b);
    result_t r;
    case (rx_phase)
      PH_TYPE: begin
        // A foreign type byte is dropped and the frame search goes on.
        if (b == type_code) begin
          frame_sum = b;
          rx_phase  = PH_SIZE;
        end
      end
      PH_SIZE: begin
        held_size = b;
        frame_sum = frame_sum + b;
        rx_phase  = PH_SUBTYPE;
      end
      PH_SUBTYPE: begin
        // A wrong subtype abandons the frame right after its header.
        if (b == subtype_code) begin
          frame_sum  = frame_sum + b;
          body_index = HEADER_LEN;
          rx_phase   = PH_BODY;
        end else begin
          rx_phase = PH_TYPE;
        end
      end
      default: begin
        frame_sum      = frame_sum + b;
        r.body_byte    = b;
        r.byte_index   = body_index;
        r.frame_size   = held_size;
        // At least one body byte is always taken, even when the size is tiny.
        r.is_last      = ({1'b0, body_index} + 9'd1 >= {1'b0, held_size});
        r.frame_status = ST_PENDING;
        if (r.is_last) begin
          // Short frames skip the checksum test entirely.
          if (held_size < MIN_FRAME) begin
            r.frame_status = ST_TOO_SHORT;
          end else if (frame_sum == 8'h00) begin
            r.frame_status = ST_OK;
          end else begin
            r.frame_status = ST_BAD_SUM;
          end
          rx_phase   = PH_TYPE;
          body_index = 8'h00;
        end else begin
          body_index = body_index + 8'd1;
        end
        expected_bodies.push_back(r);
      end
    endcase
  endtask

  // Compares one body byte transfer with the oldest expected one.
  task check_body(input result_t got);
    result_t want;
    if (expected_bodies.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: body byte %02h idx %0d with nothing expected", $realtime,
                 got.body_byte, got.byte_index);
      end
    end else begin
      want = expected_bodies.pop_front();
      bodies_checked++;
      if (got.body_byte !== want.body_byte || got.byte_index !== want.byte_index ||
          got.frame_size !== want.frame_size || got.is_last !== want.is_last ||
          got.frame_status !== want.frame_status) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: mismatch byte/idx/size/last/status exp %02h/%0d/%0d/%0b/%0d got %02h/%0d/%0d/%0b/%0d",
                   $realtime, want.body_byte, want.byte_index, want.frame_size, want.is_last,
                   want.frame_status, got.body_byte, got.byte_index, got.frame_size,
                   got.is_last, got.frame_status);
        end
      end
      if (want.is_last) begin
        case (want.frame_status)
          ST_OK:        frames_ok++;
          ST_TOO_SHORT: frames_short++;
          default:      frames_bad_sum++;
        endcase
      end
    end
  endtask

  // Queues one frame with the current type code. The body is left off when the
  // subtype does not match, since the deframer drops such a frame after its
  // header. Returns the number of bytes queued.
  function automatic int queue_frame(input logic [7:0] size, input logic [7:0] sub,
                                     input bit good_sum);
    logic [7:0] sum;
    int         n_body;
    pending_bytes.push_back(hdr_type);
    pending_bytes.push_back(size);
    pending_bytes.push_back(sub);
    if (sub != hdr_subtype) begin
      return 3;
    end
    sum    = hdr_type + size + sub;
    n_body = (size < MIN_FRAME) ? 1 : int'(size) - int'(HEADER_LEN);
    for (int i = 0; i < n_body - 1; i++) begin
      pending_bytes.push_back(8'($urandom_range(255)));
      sum = sum + pending_bytes[$];
    end
    // The closing byte brings the sum to zero, or misses it on purpose.
    if (good_sum) begin
      pending_bytes.push_back(8'h00 - sum);
    end else begin
      pending_bytes.push_back(8'h00 - sum + 8'($urandom_range(1, 255)));
    end
    return 3 + n_body;
  endfunction

  // Mostly well-formed frames of small size, with a few very long ones, plus
  // frames with a wrong subtype, broken headers and loose noise bytes.
  task automatic random_traffic(input int target);
    int         made;
    int         pick;
    int         n_tail;
    logic [7:0] size;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(49) == 0) begin
          size = 8'($urandom_range(200, 255));
        end else begin
          size = 8'($urandom_range(0, 12));
        end
        made += queue_frame(size, hdr_subtype, $urandom_range(9) != 0);
      end else if (pick < 80) begin
        made += queue_frame(8'($urandom_range(255)),
                            hdr_subtype ^ 8'($urandom_range(1, 255)), 1'b1);
      end else if (pick < 90) begin
        // A header that stops short; whatever follows lands in its place.
        pending_bytes.push_back(hdr_type);
        n_tail = $urandom_range(1, 2);
        for (int i = 0; i < n_tail; i++) begin
          pending_bytes.push_back(8'($urandom_range(255)));
        end
        made += 1 + n_tail;
      end else begin
        // Noise on the line between frames is mostly dropped, so it is not counted.
        pending_bytes.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // Writes both code registers while no bytes are offered and updates our copy.
  task automatic program_codes(input logic [7:0] type_val, input logic [7:0] sub_val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RESPONSE_TYPE;
    cfg_data  <= type_val;
    @(posedge clk);
    cfg_index <= CFG_TABLE_SUBTYPE;
    cfg_data  <= sub_val;
    @(posedge clk);
    cfg_we       <= 1'b0;
    type_code    = type_val;
    subtype_code = sub_val;
    hdr_type     = type_val;
    hdr_subtype  = sub_val;
  endtask

  // Holds the test sequence back until every queued byte has gone in and every
  // expected body byte has come out, then lets the pipeline settle.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pending_bytes.size() != 0 || rx_ch.valid || expected_bodies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: a new byte is offered once the previous one has been
  // transferred, unless the sender idles in this cycle.
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= 8'h00;
    end else if (!rx_ch.valid || rx_ch.ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= pending_bytes.pop_front();
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // Output receiver: ready drops at random at the current idle rate.
  always @(posedge clk) begin
    if (rst) begin
      tx_ch.ready <= 1'b0;
    end else begin
      tx_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: every input transfer advances the prediction, and every output
  // transfer is checked. The prediction runs first so that a result in the
  // same cycle as its byte would still find its expectation.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        predict_deframe(rx_ch.rx_byte);
        bytes_sent++;
      end
      if (tx_ch.valid && tx_ch.ready) begin
        check_body({tx_ch.body_byte, tx_ch.byte_index, tx_ch.frame_size, tx_ch.is_last,
                    status_t'(tx_ch.frame_status)});
      end
      if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Watchdog: a long spell without any transfer means the deframer has hung.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_RESPONSE_TYPE;
    cfg_data  = 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // First setting: the sender idles now and then, the receiver half the time.
    send_idle_pct = 13;
    recv_idle_pct = 51;
    program_codes(8'h5A, 8'h3C);

    // Directed frames. Foreign type bytes at both ends of the byte range are
    // dropped, then come a zero size and a size of two (both too short, one body
    // byte each), a frame with a wrong subtype that ends after its header, a
    // minimal frame with a good checksum and one whose checksum is off.
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    void'(queue_frame(8'd0, hdr_subtype, 1'b1));
    void'(queue_frame(8'd2, hdr_subtype, 1'b1));
    void'(queue_frame(8'd3, 8'h3D, 1'b1));
    void'(queue_frame(8'd4, hdr_subtype, 1'b1));
    void'(queue_frame(8'd5, hdr_subtype, 1'b0));
    // A full-size frame reaches the largest index the deframer can show.
    void'(queue_frame(8'd255, hdr_subtype, 1'b1));
    random_traffic(400);
    wait_drained();

    // Leave a frame half read across the code change: the subtype byte that
    // follows must be compared with the new subtype code.
    pending_bytes.push_back(hdr_type);
    pending_bytes.push_back(8'd6);
    wait_drained();
    program_codes(8'h00, 8'hFF);
    pending_bytes.push_back(8'hFF);
    repeat (3) pending_bytes.push_back(8'($urandom_range(255)));
    random_traffic(400);
    wait_drained();

    // Swap the idle rates between sender and receiver.
    send_idle_pct = 51;
    recv_idle_pct = 13;
    program_codes(8'hFF, 8'h00);
    random_traffic(400);
    wait_drained();

    program_codes(8'($urandom_range(255)), 8'($urandom_range(255)));
    random_traffic(400);
    wait_drained();

    // Full rate on both sides, with type and subtype codes equal.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_codes(8'h81, 8'h81);
    random_traffic(400);
    wait_drained();

    $display("Sent %0d bytes under five code settings and checked %0d body bytes.",
             bytes_sent, bodies_checked);
    $display("Frame endings seen: %0d ok, %0d too short, %0d checksum mismatch.",
             frames_ok, frames_short, frames_bad_sum);
    if (error_count == 0 && expected_bodies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rpd_pkg.sv
rtl/rpd_in_if.sv
rtl/rpd_out_if.sv
rtl/rpd_frame_fsm.sv
rtl/rpd_out_stage.sv
rtl/response_packet_deframer_core.sv
dv/response_packet_deframer_core_test.sv
